/* hw/rtl/lpf_pkg.sv */
// Shared codes, defaults and controller/datapath interface types for the packet FIFO.
`default_nettype none

package lpf_pkg;

    localparam int DEPTH_DEFAULT = 4096;

    localparam int CMD_W = 2;
    localparam int LEN_W = 16;
    localparam int BYTE_W = 8;
    localparam int STATUS_W = 3;
    localparam int USED_W = 13;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_OPEN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 3'd5;

    typedef logic [3:0] res_kind_t;

    localparam res_kind_t RES_NONE     = 4'd0;
    localparam res_kind_t RES_START_OK = 4'd1;
    localparam res_kind_t RES_FULL     = 4'd2;
    localparam res_kind_t RES_BUSY     = 4'd3;
    localparam res_kind_t RES_NO_OPEN  = 4'd4;
    localparam res_kind_t RES_PUSH     = 4'd5;
    localparam res_kind_t RES_EMPTY    = 4'd6;
    localparam res_kind_t RES_ZERO     = 4'd7;
    localparam res_kind_t RES_POP      = 4'd8;

    typedef struct packed {
        logic      latch_in;
        logic      wr_lo;
        logic      wr_hi;
        logic      wr_data;
        logic      rd_issue;
        logic      cap_lo;
        logic      load_total;
        logic      pop_data;
        logic      res_load;
        res_kind_t res_kind;
    } dp_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             write_open;
        logic             read_rem_zero;
        logic             used_lt2;
        logic             room_short;
        logic             total_zero;
    } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/lpf_dp.sv */
// Datapath of the packet FIFO: byte store, ring positions, packet counters and result registers.
`default_nettype none

module lpf_dp #(
    parameter int DEPTH = lpf_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lpf_pkg::dp_ctrl_t               ctrl,
    output lpf_pkg::dp_stat_t                    stat,
    input  wire logic [lpf_pkg::CMD_W-1:0]       command,
    input  wire logic [lpf_pkg::LEN_W-1:0]       packet_length,
    input  wire logic [lpf_pkg::BYTE_W-1:0]      data_byte,
    output logic                                 done,
    output logic [lpf_pkg::STATUS_W-1:0]         status,
    output logic [lpf_pkg::BYTE_W-1:0]           data_out,
    output logic                                 last,
    output logic [lpf_pkg::LEN_W-1:0]            current_length,
    output logic [lpf_pkg::USED_W-1:0]           used_bytes
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int EXT_W = (PTR_W > lpf_pkg::USED_W) ? PTR_W : lpf_pkg::USED_W;
    localparam int SUM_W = lpf_pkg::LEN_W + 2;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    logic [lpf_pkg::BYTE_W-1:0] mem [DEPTH];

    logic [lpf_pkg::CMD_W-1:0]   cmd_reg;
    logic [lpf_pkg::LEN_W-1:0]   len_reg;
    logic [lpf_pkg::BYTE_W-1:0]  byte_reg;
    logic [PTR_W-1:0]            wp_reg, wp_next;
    logic [PTR_W-1:0]            cp_reg, cp_next;
    logic [PTR_W-1:0]            rp_reg, rp_next;
    logic [lpf_pkg::LEN_W-1:0]   wrem_reg, wrem_next;
    logic                        wopen_reg, wopen_next;
    logic [lpf_pkg::LEN_W-1:0]   rrem_reg, rrem_next;
    logic [lpf_pkg::LEN_W-1:0]   rtotal_reg, rtotal_next;
    logic [lpf_pkg::BYTE_W-1:0]  rd_data_reg;
    logic [lpf_pkg::BYTE_W-1:0]  lo_reg;

    logic                        done_reg;
    logic [lpf_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [lpf_pkg::BYTE_W-1:0]  dout_reg, dout_next;
    logic                        last_reg, last_next;
    logic [lpf_pkg::LEN_W-1:0]   clen_reg, clen_next;

    logic                        mem_we;
    logic [lpf_pkg::BYTE_W-1:0]  mem_wdata;
    logic [PTR_W-1:0]            wp_adv;
    logic [PTR_W:0]              used_wide;
    logic [PTR_W-1:0]            used;
    logic [EXT_W-1:0]            used_ext;
    logic [SUM_W-1:0]            need;
    logic [lpf_pkg::LEN_W-1:0]   total_now;

    assign wp_adv = advance(wp_reg);

    // Committed bytes not yet read, modulo the ring size.
    assign used_wide = {1'b0, cp_reg} + (PTR_W + 1)'(DEPTH) - {1'b0, rp_reg};
    assign used = (used_wide >= (PTR_W + 1)'(DEPTH))
                ? PTR_W'(used_wide - (PTR_W + 1)'(DEPTH))
                : used_wide[PTR_W-1:0];
    assign used_ext = EXT_W'(used);

    // A start is refused when free space (DEPTH - used) is at most length plus two.
    assign need = SUM_W'(used) + SUM_W'(len_reg) + SUM_W'(2);
    assign total_now = {rd_data_reg, lo_reg};

    always_comb
    begin
        stat.cmd = cmd_reg;
        stat.write_open = wopen_reg;
        stat.read_rem_zero = (rrem_reg == '0);
        stat.used_lt2 = (used < PTR_W'(2));
        stat.room_short = (need >= SUM_W'(DEPTH));
        stat.total_zero = (total_now == '0);
    end

    always_comb
    begin
        mem_we = ctrl.wr_lo | ctrl.wr_hi | ctrl.wr_data;
        if (ctrl.wr_lo)
            mem_wdata = len_reg[7:0];
        else if (ctrl.wr_hi)
            mem_wdata = len_reg[15:8];
        else
            mem_wdata = byte_reg;
    end

    always_comb
    begin
        wp_next = wp_reg;
        cp_next = cp_reg;
        rp_next = rp_reg;
        wrem_next = wrem_reg;
        wopen_next = wopen_reg;
        rrem_next = rrem_reg;
        rtotal_next = rtotal_reg;
        if (mem_we)
            wp_next = wp_adv;
        if (ctrl.wr_hi)
        begin
            if (len_reg == '0)
                cp_next = wp_adv;
            else
            begin
                wopen_next = 1'b1;
                wrem_next = len_reg;
            end
        end
        if (ctrl.wr_data)
        begin
            wrem_next = wrem_reg - lpf_pkg::LEN_W'(1);
            if (wrem_reg == lpf_pkg::LEN_W'(1))
            begin
                wopen_next = 1'b0;
                cp_next = wp_adv;
            end
        end
        if (ctrl.rd_issue)
            rp_next = advance(rp_reg);
        if (ctrl.load_total)
        begin
            rtotal_next = total_now;
            rrem_next = total_now;
        end
        if (ctrl.pop_data)
            rrem_next = rrem_reg - lpf_pkg::LEN_W'(1);
    end

    always_comb
    begin
        status_next = lpf_pkg::ST_OK;
        dout_next = '0;
        last_next = 1'b0;
        clen_next = '0;
        unique case (ctrl.res_kind)
            lpf_pkg::RES_START_OK:
                clen_next = len_reg;
            lpf_pkg::RES_FULL:
                status_next = lpf_pkg::ST_FULL;
            lpf_pkg::RES_BUSY:
            begin
                status_next = lpf_pkg::ST_BUSY;
                clen_next = wrem_reg;
            end
            lpf_pkg::RES_NO_OPEN:
                status_next = lpf_pkg::ST_NO_OPEN;
            lpf_pkg::RES_PUSH:
                clen_next = wrem_reg - lpf_pkg::LEN_W'(1);
            lpf_pkg::RES_EMPTY:
                status_next = lpf_pkg::ST_EMPTY;
            lpf_pkg::RES_ZERO:
            begin
                status_next = lpf_pkg::ST_ZERO_LEN;
                last_next = 1'b1;
            end
            lpf_pkg::RES_POP:
            begin
                dout_next = rd_data_reg;
                last_next = (rrem_reg == lpf_pkg::LEN_W'(1));
                clen_next = rtotal_reg;
            end
            default:
            begin
                status_next = lpf_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= mem_wdata;
        if (ctrl.rd_issue)
            rd_data_reg <= mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch_in)
        begin
            cmd_reg <= command;
            len_reg <= packet_length;
            byte_reg <= data_byte;
        end
        if (ctrl.cap_lo)
            lo_reg <= rd_data_reg;
        if (ctrl.res_load)
        begin
            status_reg <= status_next;
            dout_reg <= dout_next;
            last_reg <= last_next;
            clen_reg <= clen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            cp_reg <= '0;
            rp_reg <= '0;
            wrem_reg <= '0;
            wopen_reg <= 1'b0;
            rrem_reg <= '0;
            rtotal_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            wp_reg <= wp_next;
            cp_reg <= cp_next;
            rp_reg <= rp_next;
            wrem_reg <= wrem_next;
            wopen_reg <= wopen_next;
            rrem_reg <= rrem_next;
            rtotal_reg <= rtotal_next;
            done_reg <= ctrl.res_load;
        end
    end

    assign done = done_reg;
    assign status = status_reg;
    assign data_out = dout_reg;
    assign last = last_reg;
    assign current_length = clen_reg;
    // Positions do not move while the result is shown, so the count is current.
    assign used_bytes = used_ext[lpf_pkg::USED_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/lpf_ctrl.sv */
// Controller state machine of the packet FIFO: sequences memory writes, reads and results.
`default_nettype none

module lpf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire lpf_pkg::dp_stat_t   stat,
    output lpf_pkg::dp_ctrl_t        ctrl
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_WR_HI   = 3'd2;
    localparam logic [2:0] S_RD_HI   = 3'd3;
    localparam logic [2:0] S_RD_LEN  = 3'd4;
    localparam logic [2:0] S_RD_DATA = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        ctrl.res_kind = lpf_pkg::RES_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.latch_in = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (stat.cmd)
                    lpf_pkg::CMD_START:
                    begin
                        if (stat.write_open)
                        begin
                            ctrl.res_load = 1'b1;
                            ctrl.res_kind = lpf_pkg::RES_BUSY;
                        end
                        else if (stat.room_short)
                        begin
                            ctrl.res_load = 1'b1;
                            ctrl.res_kind = lpf_pkg::RES_FULL;
                        end
                        else
                        begin
                            ctrl.wr_lo = 1'b1;
                            state_next = S_WR_HI;
                        end
                    end
                    lpf_pkg::CMD_PUSH:
                    begin
                        ctrl.res_load = 1'b1;
                        if (!stat.write_open)
                            ctrl.res_kind = lpf_pkg::RES_NO_OPEN;
                        else
                        begin
                            ctrl.wr_data = 1'b1;
                            ctrl.res_kind = lpf_pkg::RES_PUSH;
                        end
                    end
                    lpf_pkg::CMD_POP:
                    begin
                        if (!stat.read_rem_zero)
                        begin
                            ctrl.rd_issue = 1'b1;
                            state_next = S_RD_DATA;
                        end
                        else if (stat.used_lt2)
                        begin
                            ctrl.res_load = 1'b1;
                            ctrl.res_kind = lpf_pkg::RES_EMPTY;
                        end
                        else
                        begin
                            // Fetch the low header byte first.
                            ctrl.rd_issue = 1'b1;
                            state_next = S_RD_HI;
                        end
                    end
                    default:
                    begin
                        ctrl.res_load = 1'b1;
                        ctrl.res_kind = lpf_pkg::RES_NONE;
                    end
                endcase
            end
            S_WR_HI:
            begin
                ctrl.wr_hi = 1'b1;
                ctrl.res_load = 1'b1;
                ctrl.res_kind = lpf_pkg::RES_START_OK;
                state_next = S_IDLE;
            end
            S_RD_HI:
            begin
                ctrl.cap_lo = 1'b1;
                ctrl.rd_issue = 1'b1;
                state_next = S_RD_LEN;
            end
            S_RD_LEN:
            begin
                ctrl.load_total = 1'b1;
                if (stat.total_zero)
                begin
                    ctrl.res_load = 1'b1;
                    ctrl.res_kind = lpf_pkg::RES_ZERO;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctrl.rd_issue = 1'b1;
                    state_next = S_RD_DATA;
                end
            end
            S_RD_DATA:
            begin
                ctrl.pop_data = 1'b1;
                ctrl.res_load = 1'b1;
                ctrl.res_kind = lpf_pkg::RES_POP;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/length_prefixed_packet_fifo.sv */
// Top level of the length-prefixed packet FIFO: controller and datapath.
`default_nettype none

// Byte ring buffer of DEPTH entries holding packets, each stored as a two-byte
// little-endian length followed by its data. A command is taken when start is
// high and busy is low; its single result is shown for one cycle right after the
// command's last working cycle, marked by done, and the receiver cannot stall it,
// so it must take every word as it comes. A new command may be issued in the same
// cycle that done is high.
// A push, a refused start, a refused or empty pop and command code 3 end in the
// execute state; an accepted start adds a state because both header bytes go
// through the one memory write port; a pop inside a packet reads its data byte,
// and the pop that opens a packet first reads the two header bytes and then,
// unless the length is zero, the data byte, one after another through the
// single registered read port. A packet becomes visible to pops only after its
// last data byte is pushed (a zero-length packet: once its header is written).
module length_prefixed_packet_fifo #(
    parameter int DEPTH = lpf_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [lpf_pkg::CMD_W-1:0]     command,
    input  wire logic [lpf_pkg::LEN_W-1:0]     packet_length,
    input  wire logic [lpf_pkg::BYTE_W-1:0]    data_byte,
    output logic                               done,
    output logic [lpf_pkg::STATUS_W-1:0]       status,
    output logic [lpf_pkg::BYTE_W-1:0]         data_out,
    output logic                               last,
    output logic [lpf_pkg::LEN_W-1:0]          current_length,
    output logic [lpf_pkg::USED_W-1:0]         used_bytes
);

    lpf_pkg::dp_ctrl_t ctrl;
    lpf_pkg::dp_stat_t stat;

    lpf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    lpf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .command        (command),
        .packet_length  (packet_length),
        .data_byte      (data_byte),
        .done           (done),
        .status         (status),
        .data_out       (data_out),
        .last           (last),
        .current_length (current_length),
        .used_bytes     (used_bytes)
    );

endmodule

`default_nettype wire
